// ----- rtl/core/text_to_q16_16_parser_defines.svh -----
// assertion macros for the text to q16.16 parser
`ifndef TEXT_TO_Q16_16_PARSER_DEFINES_SVH
`define TEXT_TO_Q16_16_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define T2Q_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("t2q same-cycle check failed");
`define T2Q_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("t2q next-cycle check failed");
`else
`define T2Q_ASSERT_IMP(lbl, ante, cons)
`define T2Q_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/t2q_pkg.sv -----
// shared types, constants and scale function for the text to q16.16 parser
package t2q_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // fraction divider: quotient bits and working width
  localparam int SCALE_W = 17;
  localparam int QUO_W   = 17;
  localparam int DIV_W   = SCALE_W + QUO_W;
  localparam int STEP_W  = $clog2(QUO_W);

  localparam logic [3:0] DEC_LIMIT = 4'd4;
  localparam logic [3:0] HEX_LIMIT = 4'd4;
  localparam logic [3:0] BIN_LIMIT = 4'd14;

  localparam logic [SCALE_W-1:0] DEC_SCALE [5] = '{
    17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000
  };

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_t;

  // one finished string handed from front to back
  typedef struct packed {
    logic [31:0] int_acc;
    logic [15:0] frac_acc;
    radix_t      radix;
    logic [3:0]  frac_digits;
    logic        is_negative;
    logic [15:0] char_count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic idle;
    logic dividing;
    logic done;
  } bk_stat_t;

  // fraction scale for the given radix and digit count
  function automatic logic [SCALE_W-1:0] scale_of(input radix_t rx, input logic [3:0] digits);
    logic [3:0]         d;
    logic [SCALE_W-1:0] r;
    d = '0;
    r = '0;
    case (rx)
      RX_HEX: begin
        d = (digits > HEX_LIMIT) ? HEX_LIMIT : digits;
        r = SCALE_W'(1) << {d[2:0], 2'b00};
      end
      RX_BIN: begin
        d = (digits > BIN_LIMIT) ? BIN_LIMIT : digits;
        r = SCALE_W'(1) << d;
      end
      default: begin
        d = (digits > DEC_LIMIT) ? DEC_LIMIT : digits;
        r = DEC_SCALE[d[2:0]];
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/t2q_front.sv -----
// character parser: classifies each byte and accumulates the number fields
module t2q_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      char_code,
  input  t2q_pkg::q_stat_t q_stat,
  output logic            push,
  output t2q_pkg::job_t   job
);
  import t2q_pkg::*;

  typedef enum logic [5:0] {
    PH_WS     = 6'b000001,
    PH_SIGNED = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_INT    = 6'b001000,
    PH_FRAC   = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  radix_t      radix, radix_next;
  logic        is_negative, is_negative_next;
  logic [31:0] int_acc, int_acc_next;
  logic [15:0] frac_acc, frac_acc_next;
  logic [3:0]  frac_digits, frac_digits_next;
  logic [15:0] char_counter, char_counter_next;

  logic       accept;
  logic       is_ws;
  logic       do_signed;
  logic       do_int;
  logic [4:0] dg_cur;
  logic [4:0] dg_int;
  logic [3:0] limit;

  // {valid, value} of a digit in the given radix
  function automatic logic [4:0] digit_of(input radix_t rx, input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    case (rx)
      RX_HEX: begin
        if (c >= CH_0 && c <= CH_9) r = {1'b1, c[3:0]};
        else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
          r = {1'b1, c[3:0] + 4'd9};
      end
      RX_BIN: begin
        if (c == CH_0 || c == CH_1) r = {1'b1, 3'b000, c[0]};
      end
      default: begin
        if (c >= CH_0 && c <= CH_9) r = {1'b1, c[3:0]};
      end
    endcase
    return r;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign is_ws    = (char_code >= CH_TAB && char_code <= CH_CR) || char_code == CH_SPACE;
  assign dg_cur   = digit_of(radix, char_code);
  assign limit    = (radix == RX_BIN) ? BIN_LIMIT : DEC_LIMIT;

  assign job.int_acc     = int_acc;
  assign job.frac_acc    = frac_acc;
  assign job.radix       = radix;
  assign job.frac_digits = frac_digits;
  assign job.is_negative = is_negative;
  assign job.char_count  = char_counter;

  always_comb begin
    phase_next        = phase;
    radix_next        = radix;
    is_negative_next  = is_negative;
    int_acc_next      = int_acc;
    frac_acc_next     = frac_acc;
    frac_digits_next  = frac_digits;
    char_counter_next = char_counter;
    push              = 1'b0;
    do_signed         = 1'b0;
    do_int            = 1'b0;
    dg_int            = '0;
    if (accept) begin
      if (char_code == CH_NUL) begin
        push              = 1'b1;
        phase_next        = PH_WS;
        radix_next        = RX_DEC;
        is_negative_next  = 1'b0;
        int_acc_next      = '0;
        frac_acc_next     = '0;
        frac_digits_next  = '0;
        char_counter_next = '0;
      end else begin
        if (char_counter != 16'hFFFF) char_counter_next = char_counter + 16'd1;
        case (phase)
          PH_WS: begin
            if (is_ws) begin
              phase_next = PH_WS;
            end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
              is_negative_next = (char_code == CH_MINUS);
              phase_next       = PH_SIGNED;
            end else begin
              do_signed = 1'b1;
            end
          end
          PH_SIGNED: do_signed = 1'b1;
          PH_ZERO: begin
            phase_next = PH_INT;
            if (char_code == CH_LX || char_code == CH_UX) begin
              radix_next = RX_HEX;
            end else if (char_code == CH_LB || char_code == CH_UB) begin
              radix_next = RX_BIN;
            end else begin
              radix_next = RX_DEC;
              do_int     = 1'b1;
            end
          end
          PH_INT: do_int = 1'b1;
          PH_FRAC: begin
            if (dg_cur[4] && frac_digits < limit) begin
              case (radix)
                RX_HEX: frac_acc_next = {frac_acc[11:0], 4'b0000} + {12'b0, dg_cur[3:0]};
                RX_BIN: frac_acc_next = {frac_acc[14:0], 1'b0} + {12'b0, dg_cur[3:0]};
                default: frac_acc_next = {frac_acc[12:0], 3'b000} + {frac_acc[14:0], 1'b0}
                                       + {12'b0, dg_cur[3:0]};
              endcase
              frac_digits_next = frac_digits + 4'd1;
            end else begin
              phase_next = PH_IGNORE;
            end
          end
          default: phase_next = phase;
        endcase
        // leading zero may open a radix prefix
        if (do_signed) begin
          if (char_code == CH_0) begin
            phase_next = PH_ZERO;
          end else begin
            radix_next = RX_DEC;
            phase_next = PH_INT;
            do_int     = 1'b1;
          end
        end
        if (do_int) begin
          dg_int = digit_of(radix_next, char_code);
          if (dg_int[4]) begin
            phase_next = PH_INT;
            case (radix_next)
              RX_HEX: int_acc_next = {int_acc[27:0], 4'b0000} + {28'b0, dg_int[3:0]};
              RX_BIN: int_acc_next = {int_acc[30:0], 1'b0} + {28'b0, dg_int[3:0]};
              default: int_acc_next = {int_acc[28:0], 3'b000} + {int_acc[30:0], 1'b0}
                                    + {28'b0, dg_int[3:0]};
            endcase
          end else if (char_code == CH_DOT || char_code == CH_COMMA) begin
            phase_next = PH_FRAC;
          end else begin
            phase_next = PH_IGNORE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WS;
      radix        <= RX_DEC;
      is_negative  <= 1'b0;
      int_acc      <= '0;
      frac_acc     <= '0;
      frac_digits  <= '0;
      char_counter <= '0;
    end else begin
      phase        <= phase_next;
      radix        <= radix_next;
      is_negative  <= is_negative_next;
      int_acc      <= int_acc_next;
      frac_acc     <= frac_acc_next;
      frac_digits  <= frac_digits_next;
      char_counter <= char_counter_next;
    end
  end

endmodule

// ----- rtl/core/t2q_queue.sv -----
// short job queue between the parser and the fraction divider
module t2q_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  t2q_pkg::job_t    push_job,
  input  logic             pop,
  output t2q_pkg::job_t    head_job,
  output t2q_pkg::q_stat_t q_stat
);
  import t2q_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/t2q_back.sv -----
// rounding fraction divider, sign and output register
module t2q_back (
  input  logic               clk,
  input  logic               rst,
  input  t2q_pkg::job_t      job,
  input  t2q_pkg::q_stat_t   q_stat,
  output logic               pop,
  output t2q_pkg::bk_stat_t  bk_stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [15:0]        chars_seen
);
  import t2q_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } bk_state_t;

  bk_state_t          state;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dsh;
  logic [QUO_W-1:0]   quo;
  logic [STEP_W-1:0]  step;
  logic [31:0]        int_acc;
  logic               is_negative;
  logic [15:0]        char_count;

  logic [SCALE_W-1:0] scale;
  logic               ge;
  logic               load_out;
  logic [31:0]        sum;
  logic [31:0]        result;

  assign pop       = (state == BK_IDLE) && !q_stat.empty;
  assign scale     = scale_of(job.radix, job.frac_digits);
  assign ge        = (rem >= dsh);
  assign load_out  = (state == BK_DONE) && (!out_valid || !out_stall);
  assign sum       = {int_acc[15:0], 16'h0000} + {{(32-QUO_W){1'b0}}, quo};
  assign result    = is_negative ? (32'd0 - sum) : sum;

  assign bk_stat.idle     = (state == BK_IDLE);
  assign bk_stat.dividing = (state == BK_DIV);
  assign bk_stat.done     = (state == BK_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (pop) begin
            state <= BK_DIV;
            step  <= '0;
          end
        end
        BK_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(QUO_W - 1)) state <= BK_DONE;
        end
        BK_DONE: begin
          if (load_out) state <= BK_IDLE;
        end
        default: state <= BK_IDLE;
      endcase
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // dividend is frac*2^17 + scale, divisor 2*scale: a rounded quotient
  always_ff @(posedge clk) begin
    if (pop) begin
      rem         <= {1'b0, job.frac_acc, {QUO_W{1'b0}}} + {{QUO_W{1'b0}}, scale};
      dsh         <= {scale, {QUO_W{1'b0}}};
      quo         <= '0;
      int_acc     <= job.int_acc;
      is_negative <= job.is_negative;
      char_count  <= job.char_count;
    end else if (state == BK_DIV) begin
      if (ge) rem <= rem - dsh;
      quo <= {quo[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
    end
    if (load_out) begin
      value      <= $signed(result);
      chars_seen <= char_count;
    end
  end

endmodule

// ----- rtl/core/text_to_q16_16_parser.sv -----
// Streaming text to signed Q16.16 parser.
// Input channel: in_valid / in_stall with char_code, one byte per transaction.
// A zero byte ends the string; every other byte is parsed in the cycle it is
// accepted, so text streams in at one byte per clock while in_stall is low.
// Output channel: out_valid / out_stall with value (Q16.16) and chars_seen,
// one transaction per terminated string.
// The 17-step restoring divider that rounds the fraction produces the result.
// The divider handles one string at a time; a 2-entry queue holds
// finished strings so parsing of following text goes on meanwhile.
// in_stall rises only when that queue is full.
// If the receiver stalls, the result holds in the output register; the
// divider then waits with its next result and the queue fills behind it.
// Reset (rst, synchronous, active high) returns the parser to whitespace
// skipping, empties the queue and drops any pending result.
module text_to_q16_16_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [15:0]        chars_seen
);
  import t2q_pkg::*;

`include "text_to_q16_16_parser_defines.svh"

  logic     push;
  logic     pop;
  job_t     push_job;
  job_t     head_job;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  t2q_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  t2q_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  t2q_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (head_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .bk_stat    (bk_stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .chars_seen (chars_seen)
  );

  // a terminator transaction always lands in the queue
  `T2Q_ASSERT_IMP(a_term_push, in_valid && !in_stall && (char_code == CH_NUL), push)
  // an idle divider picks up waiting work at once
  `T2Q_ASSERT_NXT(a_idle_start, bk_stat.idle && !q_stat.empty, bk_stat.dividing)
  // a new result only comes from a finished division
  `T2Q_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(bk_stat.done))

endmodule
